>>> src/rse_pkg.sv
package rse_pkg;

  localparam int MAX_PARITY = 32;
  localparam int PAR_CNT_W  = $clog2(MAX_PARITY + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY   = 1'b1;

  localparam logic [5:0] RESET_PARITY_COUNT = 6'd16;
  localparam logic [8:0] RESET_FIELD_POLY   = 9'h11d;

  typedef logic [MAX_PARITY-1:0][7:0] coeff_vec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } q_item_t;

  typedef struct packed {
    logic                 busy;
    logic [PAR_CNT_W-1:0] count;
  } gen_stat_t;

  typedef enum logic {
    ST_RUN,
    ST_PARITY
  } back_state_e;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ red) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

>>> src/reed_solomon_systematic_encoder.sv
// Systematic Reed-Solomon encoder, GF(2^8), up to 32 parity symbols.
// Input queue: message bytes enter with push while full is low; last marks
// the final byte of a message. Result queue: while empty is low the oldest
// result sits on out_byte_o and its flags; pop takes it.
// Each message byte comes back unchanged; after the last byte the parity
// bytes follow, highest-order first, the final one with end_of_codeword_o.
// Config channel: cfg_valid_i/cfg_ready_o, index 0 = parity count,
// index 1 = field polynomial; ready is always high. Writes take effect at
// the next message, but the polynomial also reduces the remainder at once.
// A byte passes through the input queue and then the output register.
// Throughput: 1 byte per cycle, set by the parity LFSR update, while pop
// keeps up; after a last byte its n parity bytes go out before the next
// input byte. A message's first byte after reset or a config write waits
// while the generator unit forms one coefficient factor per cycle.
// Reset empties both queues, clears the remainder and loads parity count 16
// and polynomial 0x11d. If pop stays low the output register holds, the
// 2-entry input queue fills and full rises.
module reed_solomon_systematic_encoder import rse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic                  is_parity_o,
  output logic                  end_of_codeword_o,
  output logic                  too_long_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [5:0] parity_count_q, parity_count_d;
  logic [8:0] field_poly_q, field_poly_d;
  logic       stale_q, stale_d;
  logic       cfg_wr;
  logic       q_valid;
  q_item_t    q_item;
  logic       q_pop;
  logic       gen_start;
  gen_stat_t  gen_stat;
  coeff_vec_t coeff;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    parity_count_d = parity_count_q;
    field_poly_d   = field_poly_q;
    stale_d        = stale_q;
    if (gen_start) begin
      stale_d = 1'b0;
    end
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_PARITY_COUNT: begin
          parity_count_d = cfg_data_i[5:0];
          stale_d        = 1'b1;
        end
        CFG_FIELD_POLY: begin
          field_poly_d = cfg_data_i[8:0];
          stale_d      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_count_q <= RESET_PARITY_COUNT;
      field_poly_q   <= RESET_FIELD_POLY;
      stale_q        <= 1'b1;
    end else begin
      parity_count_q <= parity_count_d;
      field_poly_q   <= field_poly_d;
      stale_q        <= stale_d;
    end
  end

  rse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  rse_gen u_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (gen_start),
    .parity_count_i (parity_count_q),
    .red_i          (field_poly_q[7:0]),
    .coeff_o        (coeff),
    .stat_o         (gen_stat)
  );

  rse_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .stale_i           (stale_q),
    .gen_start_o       (gen_start),
    .gen_stat_i        (gen_stat),
    .coeff_i           (coeff),
    .red_i             (field_poly_q[7:0]),
    .empty             (empty),
    .pop               (pop),
    .out_byte_o        (out_byte_o),
    .is_parity_o       (is_parity_o),
    .end_of_codeword_o (end_of_codeword_o),
    .too_long_o        (too_long_o)
  );

endmodule

>>> src/rse_front.sv
module rse_front import rse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  logic    [7:0] data_byte_i,
  input  logic    last_i,
  output logic    q_valid_o,
  output q_item_t q_item_o,
  input  logic    q_pop_i
);

  q_item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                mid_q, mid_d;
  logic                push_ok;
  logic                pop_ok;

  assign full      = (cnt_q == QCNT_W'(QDEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];
  assign push_ok   = push && !full;
  assign pop_ok    = q_pop_i && q_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    mid_d = mid_q;
    if (push_ok) begin
      wr_d  = wr_q + 1'b1;
      mid_d = !last_i;
    end
    if (pop_ok) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      mid_q <= 1'b0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      mid_q <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= '{data: data_byte_i, last: last_i, first: !mid_q};
    end
  end

endmodule

>>> src/rse_gen.sv
module rse_gen import rse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [5:0] parity_count_i,
  input  logic [7:0] red_i,
  output coeff_vec_t coeff_o,
  output gen_stat_t  stat_o
);

  coeff_vec_t           g_q, g_d;
  logic [7:0]           root_q, root_d;
  logic [PAR_CNT_W-1:0] n_q, n_d;
  logic [PAR_CNT_W-1:0] step_q, step_d;
  logic                 busy;

  assign busy    = (step_q < n_q);
  assign coeff_o = g_q;
  assign stat_o  = '{busy: busy, count: n_q};

  always_comb begin
    g_d    = g_q;
    root_d = root_q;
    n_d    = n_q;
    step_d = step_q;
    if (start_i) begin
      g_d    = '0;
      root_d = 8'h01;
      step_d = '0;
      n_d    = (parity_count_i > 6'(MAX_PARITY)) ? PAR_CNT_W'(MAX_PARITY)
                                                 : PAR_CNT_W'(parity_count_i);
    end else if (busy) begin
      g_d[0] = g_q[0] ^ root_q;
      for (int k = 1; k < MAX_PARITY; k++) begin
        g_d[k] = g_q[k] ^ gf_mul(g_q[k-1], root_q, red_i);
      end
      root_d = gf_mul(root_q, 8'h02, red_i);
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= PAR_CNT_W'(RESET_PARITY_COUNT);
      step_q <= PAR_CNT_W'(RESET_PARITY_COUNT);
    end else begin
      n_q    <= n_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q    <= g_d;
    root_q <= root_d;
  end

endmodule

>>> src/rse_back.sv
module rse_back import rse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  q_item_t    q_item_i,
  output logic       q_pop_o,
  input  logic       stale_i,
  output logic       gen_start_o,
  input  gen_stat_t  gen_stat_i,
  input  coeff_vec_t coeff_i,
  input  logic [7:0] red_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_parity_o,
  output logic       end_of_codeword_o,
  output logic       too_long_o
);

  back_state_e          state_q, state_d;
  coeff_vec_t           rem_q, rem_d;
  coeff_vec_t           rem_sh, rem_lfsr;
  logic [7:0]           cnt_q, cnt_d, cnt_inc;
  logic                 ovf_q, ovf_d, ovf_new;
  logic [PAR_CNT_W-1:0] left_q, left_d;
  logic [PAR_CNT_W-1:0] n;
  logic [7:0]           fb;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 is_par_q, is_par_d;
  logic                 eoc_q, eoc_d;
  logic                 tl_q, tl_d;
  logic                 out_ready;

  assign n                 = gen_stat_i.count;
  assign out_ready         = !out_valid_q || pop;
  assign empty             = !out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign is_parity_o       = is_par_q;
  assign end_of_codeword_o = eoc_q;
  assign too_long_o        = tl_q;

  assign fb      = q_item_i.data ^ rem_q[0];
  assign rem_sh  = coeff_vec_t'({8'h00, rem_q[MAX_PARITY-1:1]});
  assign cnt_inc = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
  assign ovf_new = ovf_q || (({1'b0, cnt_inc} + 9'(n)) > 9'd255);

  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) begin
      rem_lfsr[j] = rem_sh[j] ^ gf_mul(coeff_i[j], fb, red_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    is_par_d    = is_par_q;
    eoc_d       = eoc_q;
    tl_d        = tl_q;
    q_pop_o     = 1'b0;
    gen_start_o = 1'b0;
    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_RUN: begin
        if (q_valid_i && q_item_i.first && stale_i) begin
          gen_start_o = 1'b1;
        end else if (q_valid_i && !gen_stat_i.busy && out_ready) begin
          q_pop_o     = 1'b1;
          rem_d       = rem_lfsr;
          cnt_d       = cnt_inc;
          ovf_d       = ovf_new;
          out_valid_d = 1'b1;
          out_byte_d  = q_item_i.data;
          is_par_d    = 1'b0;
          eoc_d       = q_item_i.last && (n == '0);
          tl_d        = ovf_new;
          if (q_item_i.last) begin
            cnt_d = '0;
            if (n == '0) begin
              ovf_d = 1'b0;
            end else begin
              state_d = ST_PARITY;
              left_d  = n;
            end
          end
        end
      end
      ST_PARITY: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_byte_d  = rem_q[0];
          is_par_d    = 1'b1;
          eoc_d       = (left_q == PAR_CNT_W'(1));
          tl_d        = ovf_q;
          rem_d       = rem_sh;
          left_d      = left_q - 1'b1;
          if (left_q == PAR_CNT_W'(1)) begin
            state_d = ST_RUN;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rem_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    is_par_q   <= is_par_d;
    eoc_q      <= eoc_d;
    tl_q       <= tl_d;
  end

`ifndef ASSERT_OFF
  a_no_pop_in_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PARITY) |-> !q_pop_o)
    else $error("input consumed while parity drains");
  a_pop_needs_coeffs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!gen_stat_i.busy && !(q_item_i.first && stale_i)))
    else $error("byte consumed with stale generator");
  a_parity_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PARITY && out_ready && left_q == PAR_CNT_W'(1))
      |=> (state_q == ST_RUN && eoc_q && is_par_q && out_valid_q))
    else $error("codeword did not end on last parity byte");
  a_parity_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PARITY) |-> (left_q != '0))
    else $error("parity state with nothing left");
`endif

endmodule

>>> tb/rs_encode_checker.sv
module rs_encode_checker import rse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [7:0]            out_byte_o,
  input  logic                  is_parity_o,
  input  logic                  end_of_codeword_o,
  input  logic                  too_long_o,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fails,
  output int unsigned           pending
);

  typedef struct packed {
    logic [7:0] sym;
    logic       parity;
    logic       eoc;
    logic       too_long;
  } codeword_sym_t;

  codeword_sym_t codeword_q[$];

  logic [5:0]  reg_parity;
  logic [8:0]  reg_poly;
  logic [7:0]  lfsr [MAX_PARITY];
  logic [7:0]  gen_coef [MAX_PARITY];
  logic [7:0]  msg_len;
  bit          overflow;
  bit          coef_stale;
  int          latched_n;

  // Horner form: fold in the bits of b from the top down.
  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] red);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      acc = acc[7] ? ({acc[6:0], 1'b0} ^ red) : {acc[6:0], 1'b0};
      if (b[k]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  function automatic void build_generator();
    logic [7:0] g [MAX_PARITY+1];
    logic [7:0] root;
    int         n;
    n = (reg_parity > MAX_PARITY) ? MAX_PARITY : int'(reg_parity);
    for (int k = 0; k <= MAX_PARITY; k++) begin
      g[k] = 8'h00;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k >= 1; k--) begin
        g[k] = g[k] ^ gf_product(g[k-1], root, reg_poly[7:0]);
      end
      root = gf_product(root, 8'h02, reg_poly[7:0]);
    end
    for (int k = 0; k < MAX_PARITY; k++) begin
      gen_coef[k] = (k < n) ? g[k+1] : 8'h00;
    end
    latched_n = n;
    coef_stale = 1'b0;
  endfunction

  function automatic void encode_byte(input logic [7:0] d, input logic is_last);
    codeword_sym_t s;
    logic [7:0]    fb;
    int            n;
    if (msg_len == 8'd0 && coef_stale) begin
      build_generator();
    end
    n = latched_n;
    if (msg_len != 8'd255) begin
      msg_len++;
    end
    if (int'(msg_len) + n > 255) begin
      overflow = 1'b1;
    end
    // reduction always follows the current polynomial register
    if (n > 0) begin
      fb = d ^ lfsr[0];
      for (int j = 0; j < n - 1; j++) begin
        lfsr[j] = lfsr[j+1] ^ gf_product(gen_coef[j], fb, reg_poly[7:0]);
      end
      lfsr[n-1] = gf_product(gen_coef[n-1], fb, reg_poly[7:0]);
    end
    s = '{sym: d, parity: 1'b0, eoc: is_last && n == 0, too_long: overflow};
    codeword_q.push_back(s);
    if (is_last) begin
      for (int j = 0; j < n; j++) begin
        s = '{sym: lfsr[j], parity: 1'b1, eoc: j == n - 1, too_long: overflow};
        codeword_q.push_back(s);
      end
      for (int j = 0; j < MAX_PARITY; j++) begin
        lfsr[j] = 8'h00;
      end
      msg_len = 8'd0;
      overflow = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    codeword_sym_t want;
    if (!rst_ni) begin
      codeword_q.delete();
      reg_parity = RESET_PARITY_COUNT;
      reg_poly = RESET_FIELD_POLY;
      for (int j = 0; j < MAX_PARITY; j++) begin
        lfsr[j] = 8'h00;
        gen_coef[j] = 8'h00;
      end
      msg_len = 8'd0;
      overflow = 1'b0;
      coef_stale = 1'b1;
      latched_n = 16;
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PARITY_COUNT: begin
            reg_parity = cfg_data_i[5:0];
            coef_stale = 1'b1;
          end
          CFG_FIELD_POLY: begin
            reg_poly = cfg_data_i;
            coef_stale = 1'b1;
          end
        endcase
      end
      if (push && !full) begin
        encode_byte(data_byte_i, last_i);
      end
      if (pop && !empty) begin
        if (codeword_q.size() == 0) begin
          $error("unexpected result transaction: out_byte %0h", out_byte_o);
          fails++;
        end else begin
          want = codeword_q.pop_front();
          check_field("out_byte", want.sym, out_byte_o);
          check_field("is_parity", {7'd0, want.parity}, {7'd0, is_parity_o});
          check_field("end_of_codeword", {7'd0, want.eoc}, {7'd0, end_of_codeword_o});
          check_field("too_long", {7'd0, want.too_long}, {7'd0, too_long_o});
        end
      end
      pending = codeword_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import rse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [7:0]            data_byte_i;
  logic                  last_i;
  logic                  empty;
  logic                  pop;
  logic [7:0]            out_byte_o;
  logic                  is_parity_o;
  logic                  end_of_codeword_o;
  logic                  too_long_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fails;
  int unsigned pending;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned msg_left;
  int unsigned random_items;
  int unsigned phase_items;
  int unsigned hold_left;
  int unsigned stretch_left;
  int unsigned stall_pct;
  bit          hold_req;

  reed_solomon_systematic_encoder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte_i),
    .last_i            (last_i),
    .empty             (empty),
    .pop               (pop),
    .out_byte_o        (out_byte_o),
    .is_parity_o       (is_parity_o),
    .end_of_codeword_o (end_of_codeword_o),
    .too_long_o        (too_long_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  rs_encode_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte_i),
    .last_i            (last_i),
    .empty             (empty),
    .pop               (pop),
    .out_byte_o        (out_byte_o),
    .is_parity_o       (is_parity_o),
    .end_of_codeword_o (end_of_codeword_o),
    .too_long_o        (too_long_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .fails             (fails),
    .pending           (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall stretches, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    hold_left = 0;
    stretch_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
        pop <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(16, 64);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        stretch_left--;
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push <= 1'b1;
    data_byte_i <= d;
    last_i <= is_last;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  // stop sending and wait until every expected result has been taken
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned items);
    logic [5:0] n;
    case ($urandom_range(0, 19))
      0: n = 6'd0;
      1: n = 6'($urandom_range(33, 63));
      2, 3, 4: n = 6'($urandom_range(17, 32));
      default: n = 6'($urandom_range(1, 8));
    endcase
    settle();
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_PARITY_COUNT, {3'($urandom_range(0, 7)), n});
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0, 1: write_reg(CFG_FIELD_POLY, 9'($urandom_range(0, 255)));
        2, 3: write_reg(CFG_FIELD_POLY, 9'($urandom_range(256, 511)));
        default: write_reg(CFG_FIELD_POLY, RESET_FIELD_POLY);
      endcase
    end
    // messages may run across phase boundaries, so config lands mid-message
    for (int unsigned i = 0; i < items; i++) begin
      if (msg_left == 0) begin
        msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      end
      send_byte(8'($urandom_range(0, 255)), msg_left == 1);
      msg_left--;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    data_byte_i = 8'h00;
    last_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PARITY_COUNT;
    cfg_data_i = '0;
    hold_req = 1'b0;
    cycles = 0;
    burst_left = 0;
    msg_left = 0;
    random_items = 0;
    phase_items = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: 16 parity, 0x11d
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'ha5, 1'b1);

    // config write in the middle of a message
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    settle();
    write_reg(CFG_PARITY_COUNT, 9'd3);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // no parity symbols
    settle();
    write_reg(CFG_PARITY_COUNT, 9'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);

    // parity count saturates, polynomial without its top bit
    settle();
    write_reg(CFG_PARITY_COUNT, 9'd63);
    write_reg(CFG_FIELD_POLY, 9'h01d);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'hff, 1'b1);

    settle();
    write_reg(CFG_PARITY_COUNT, 9'd1);
    write_reg(CFG_FIELD_POLY, 9'h1ff);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);

    // non-primitive polynomial x^8
    settle();
    write_reg(CFG_PARITY_COUNT, 9'd5);
    write_reg(CFG_FIELD_POLY, 9'h100);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h7f, 1'b1);

    // upper data bits of the count register are dropped
    settle();
    write_reg(CFG_PARITY_COUNT, 9'h1c2);
    send_byte(8'h5a, 1'b1);

    settle();
    write_reg(CFG_PARITY_COUNT, 9'd32);
    write_reg(CFG_FIELD_POLY, RESET_FIELD_POLY);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // overlong message: too_long from byte 224 on;
    // the receiver holds off meanwhile so the input side backs up
    settle();
    hold_req = 1'b1;
    for (int unsigned i = 0; i < 226; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 225);
    end

    while (random_items < 24) begin
      if ($urandom_range(0, 5) == 0) begin
        hold_req = 1'b1;
      end
      burst_left = 0;
      phase_items = $urandom_range(6, 12);
      random_phase(phase_items);
      random_items += phase_items;
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> reed_solomon_systematic_encoder.f
src/rse_pkg.sv
src/rse_front.sv
src/rse_gen.sv
src/rse_back.sv
src/reed_solomon_systematic_encoder.sv
tb/rs_encode_checker.sv
tb/testbench.sv
